// ===== hw/rtl/cmms_pkg.sv =====
package cmms_pkg;

  localparam int unsigned PtW      = 20;
  localparam int unsigned EtaW     = 16;
  localparam int unsigned PhiW     = 15;
  localparam int unsigned StatusW  = 8;
  localparam int unsigned SpeciesW = 25;
  localparam int unsigned IdW      = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned SqW      = 32;
  localparam int unsigned MaxSlots = 4;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegUseStatusTwo = 3'd0;
  localparam logic [CfgIdxW-1:0] RegUseSkipList  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSkipIdA      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSkipIdB      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSkipIdC      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSkipIdD      = 3'd5;

  // Phi in units of 1/4096 rad.
  localparam logic signed [16:0] PiFx    = 17'sd12868;
  localparam logic signed [16:0] TwoPiFx = 17'sd25736;

  // Cone radius 0.5 squared, in (1/4096)^2 units.
  localparam logic [SqW:0] ConeSq = 33'd4194304;

  localparam logic [StatusW-1:0] StatusDrop    = 8'd3;
  localparam logic [StatusW-1:0] StatusMaxKeep = 8'd1;

  localparam logic [SpeciesW-1:0] NuE   = 25'd12;
  localparam logic [SpeciesW-1:0] NuMu  = 25'd14;
  localparam logic [SpeciesW-1:0] NuTau = 25'd16;

  localparam logic signed [SpeciesW-1:0] NoSpecies = -25'sd1;

  typedef struct packed {
    logic use_status_two;
    logic use_skip_list;
  } cfg_mode_t;

  // One candidate after the cheap tests and the squaring step.
  typedef struct packed {
    logic                       pre_ok;
    logic [SqW-1:0]             deta_sq;
    logic [SqW-1:0]             dphi_sq;
    logic [PtW-1:0]             pt;
    logic signed [SpeciesW-1:0] species;
  } cand_t;

endpackage

// ===== hw/rtl/cmms_cfg.sv =====
module cmms_cfg
  import cmms_pkg::*;
#(
  parameter int unsigned SKIP_SLOTS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [CfgIdxW-1:0]                cfg_idx_i,
  input  logic [CfgDataW-1:0]               cfg_data_i,
  output cfg_mode_t                         mode_o,
  output logic [SKIP_SLOTS-1:0][IdW-1:0]    skip_ids_o
);

  cfg_mode_t mode_q;
  logic [SKIP_SLOTS-1:0][IdW-1:0] skip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegUseStatusTwo: mode_q.use_status_two <= cfg_data_i[0];
        RegUseSkipList:  mode_q.use_skip_list  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < SKIP_SLOTS; i++) begin : g_slot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        skip_q[i] <= '0;
      end else if (cfg_we_i && (cfg_idx_i == RegSkipIdA + CfgIdxW'(i))) begin
        skip_q[i] <= cfg_data_i[IdW-1:0];
      end
    end
  end

  assign mode_o     = mode_q;
  assign skip_ids_o = skip_q;

endmodule

// ===== hw/rtl/cmms_test.sv =====
module cmms_test
  import cmms_pkg::*;
#(
  parameter int unsigned SKIP_SLOTS = 4
) (
  input  cfg_mode_t                       mode_i,
  input  logic [SKIP_SLOTS-1:0][IdW-1:0]  skip_ids_i,
  input  logic                            present_i,
  input  logic [PtW-1:0]                  cand_pt_i,
  input  logic signed [EtaW-1:0]          cand_eta_i,
  input  logic signed [PhiW-1:0]          cand_phi_i,
  input  logic [StatusW-1:0]              cand_status_i,
  input  logic signed [SpeciesW-1:0]      cand_species_i,
  input  logic [PtW-1:0]                  ref_pt_i,
  input  logic signed [EtaW-1:0]          ref_eta_i,
  input  logic signed [PhiW-1:0]          ref_phi_i,
  output cand_t                           cand_o
);

  logic                status_ok;
  logic                skipped;
  logic                slot_hit;
  logic                pt_ok;
  logic [SpeciesW-1:0] spc_abs;
  logic signed [16:0]  deta;
  logic signed [16:0]  dphi_raw;
  logic signed [16:0]  dphi;
  logic signed [33:0]  deta_prod;
  logic signed [33:0]  dphi_prod;

  always_comb begin
    if (mode_i.use_status_two) begin
      status_ok = (cand_status_i != StatusDrop);
    end else begin
      status_ok = (cand_status_i <= StatusMaxKeep);
    end
  end

  assign spc_abs = cand_species_i[SpeciesW-1] ? (~cand_species_i + 25'd1) : cand_species_i;

  always_comb begin
    slot_hit = 1'b0;
    for (int i = 0; i < SKIP_SLOTS; i++) begin
      if ((skip_ids_i[i] != '0) && ({1'b0, skip_ids_i[i]} == spc_abs)) begin
        slot_hit = 1'b1;
      end
    end
  end

  assign skipped = mode_i.use_skip_list ? slot_hit
                 : ((spc_abs == NuE) || (spc_abs == NuMu) || (spc_abs == NuTau));

  assign pt_ok = ({cand_pt_i, 1'b0} > {1'b0, ref_pt_i});

  // Differences are taken in 17 bits, one bit wider than eta and two wider than phi, so they cannot overflow.
  assign deta     = {cand_eta_i[EtaW-1], cand_eta_i} - {ref_eta_i[EtaW-1], ref_eta_i};
  assign dphi_raw = {{2{cand_phi_i[PhiW-1]}}, cand_phi_i} - {{2{ref_phi_i[PhiW-1]}}, ref_phi_i};

  always_comb begin
    if (dphi_raw > PiFx) begin
      dphi = dphi_raw - TwoPiFx;
    end else if (dphi_raw <= -PiFx) begin
      dphi = dphi_raw + TwoPiFx;
    end else begin
      dphi = dphi_raw;
    end
  end

  assign deta_prod = deta * deta;
  assign dphi_prod = dphi * dphi;

  assign cand_o.pre_ok  = present_i && status_ok && !skipped && pt_ok;
  assign cand_o.deta_sq = deta_prod[SqW-1:0];
  assign cand_o.dphi_sq = dphi_prod[SqW-1:0];
  assign cand_o.pt      = cand_pt_i;
  assign cand_o.species = cand_species_i;

endmodule

// ===== hw/rtl/cmms_acc.sv =====
module cmms_acc
  import cmms_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic                        last_i,
  input  cand_t                       cand_i,
  input  logic                        out_stall_i,
  output logic                        out_free_o,
  output logic                        out_valid_o,
  output logic                        found_o,
  output logic signed [SpeciesW-1:0]  best_species_o,
  output logic [PtW-1:0]              best_pt_out_o
);

  logic                       have_q, have_d;
  logic [PtW-1:0]             pt_q, pt_d;
  logic signed [SpeciesW-1:0] id_q, id_d;
  logic                       ov_q, ov_d;
  logic                       found_q;
  logic signed [SpeciesW-1:0] spc_q;
  logic [PtW-1:0]             opt_q;
  logic                       in_cone;
  logic                       take;
  logic                       cur_have;
  logic [PtW-1:0]             cur_pt;
  logic signed [SpeciesW-1:0] cur_id;

  assign in_cone = ({1'b0, cand_i.deta_sq} + {1'b0, cand_i.dphi_sq}) < ConeSq;
  // A strictly larger momentum wins, so ties keep the earliest match.
  assign take    = fire_i && cand_i.pre_ok && in_cone && (!have_q || (cand_i.pt > pt_q));

  assign cur_have = have_q || take;
  assign cur_pt   = take ? cand_i.pt : pt_q;
  assign cur_id   = take ? cand_i.species : id_q;

  assign out_free_o = !ov_q || !out_stall_i;

  always_comb begin
    have_d = cur_have;
    pt_d   = cur_pt;
    id_d   = cur_id;
    ov_d   = ov_q && out_stall_i;
    if (fire_i && last_i) begin
      have_d = 1'b0;
      pt_d   = '0;
      id_d   = NoSpecies;
      ov_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      pt_q   <= '0;
      id_q   <= NoSpecies;
      ov_q   <= 1'b0;
    end else begin
      have_q <= have_d;
      pt_q   <= pt_d;
      id_q   <= id_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && last_i) begin
      found_q <= cur_have;
      spc_q   <= cur_id;
      opt_q   <= cur_pt;
    end
  end

  assign out_valid_o    = ov_q;
  assign found_o        = found_q;
  assign best_species_o = spc_q;
  assign best_pt_out_o  = opt_q;

endmodule

// ===== hw/rtl/cone_match_max_pt_selector_top.sv =====
// Cone-match maximum-momentum selector. Candidates stream in one beat per
// clock while in_stall_o is low, each carrying the reference direction and
// momentum it is tested against. A candidate matches when it passes the
// status filter, is not in the skip set, has more than half the reference
// momentum and lies inside a cone of radius 0.5 in (eta, phi), with the phi
// difference wrapped into (-pi, pi]. The block keeps the highest-momentum
// match of a pass; ties keep the earliest. The beat flagged last_item closes
// the pass and yields one result beat with found, the winning species and its
// momentum (-1 and 0 when nothing matched). The pipeline takes one input beat
// every cycle while in_stall_o is low; a result passes through the input
// register, the test and square stage and the result register of the
// best-match accumulator. Input backpressure occurs only when a finished
// result is held in the result register by out_stall_i and another last beat
// reaches the accumulator. Configuration must be written while the pipeline
// is empty; the block does not enforce this. Skip slots beyond SKIP_SLOTS
// are ignored, as are writes to indexes past the register list.
module cone_match_max_pt_selector_top
  import cmms_pkg::*;
#(
  parameter int unsigned SKIP_SLOTS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxW-1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        particle_present_i,
  input  logic [PtW-1:0]              cand_pt_i,
  input  logic signed [EtaW-1:0]      cand_eta_i,
  input  logic signed [PhiW-1:0]      cand_phi_i,
  input  logic [StatusW-1:0]          cand_status_i,
  input  logic signed [SpeciesW-1:0]  cand_species_i,
  input  logic [PtW-1:0]              ref_pt_i,
  input  logic signed [EtaW-1:0]      ref_eta_i,
  input  logic signed [PhiW-1:0]      ref_phi_i,
  input  logic                        last_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic signed [SpeciesW-1:0]  best_species_o,
  output logic [PtW-1:0]              best_pt_out_o
);

  cfg_mode_t                      mode;
  logic [SKIP_SLOTS-1:0][IdW-1:0] skip_ids;

  // Stage one: the registered input beat.
  logic                       s1_valid_q;
  logic                       s1_present_q;
  logic [PtW-1:0]             s1_cpt_q;
  logic signed [EtaW-1:0]     s1_ceta_q;
  logic signed [PhiW-1:0]     s1_cphi_q;
  logic [StatusW-1:0]         s1_status_q;
  logic signed [SpeciesW-1:0] s1_species_q;
  logic [PtW-1:0]             s1_rpt_q;
  logic signed [EtaW-1:0]     s1_reta_q;
  logic signed [PhiW-1:0]     s1_rphi_q;
  logic                       s1_last_q;

  // Stage two: tested candidate with its squared distances.
  logic  s2_valid_q;
  logic  s2_last_q;
  cand_t s2_cand_q;
  cand_t s2_cand_d;

  logic in_accept;
  logic s1_go;
  logic s2_go;
  logic s2_fire;
  logic out_free;

  cmms_cfg #(
    .SKIP_SLOTS(SKIP_SLOTS)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .mode_o    (mode),
    .skip_ids_o(skip_ids)
  );

  // Only a last beat can wait in stage two, and only for the result register.
  assign s2_go     = !s2_last_q || out_free;
  assign s2_fire   = s2_valid_q && s2_go;
  assign s1_go     = !s2_valid_q || s2_go;
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_go) begin
        s2_valid_q <= 1'b1;
      end else if (s2_go) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_present_q <= particle_present_i;
      s1_cpt_q     <= cand_pt_i;
      s1_ceta_q    <= cand_eta_i;
      s1_cphi_q    <= cand_phi_i;
      s1_status_q  <= cand_status_i;
      s1_species_q <= cand_species_i;
      s1_rpt_q     <= ref_pt_i;
      s1_reta_q    <= ref_eta_i;
      s1_rphi_q    <= ref_phi_i;
      s1_last_q    <= last_item_i;
    end
    if (s1_valid_q && s1_go) begin
      s2_cand_q <= s2_cand_d;
      s2_last_q <= s1_last_q;
    end
  end

  cmms_test #(
    .SKIP_SLOTS(SKIP_SLOTS)
  ) u_test (
    .mode_i        (mode),
    .skip_ids_i    (skip_ids),
    .present_i     (s1_present_q),
    .cand_pt_i     (s1_cpt_q),
    .cand_eta_i    (s1_ceta_q),
    .cand_phi_i    (s1_cphi_q),
    .cand_status_i (s1_status_q),
    .cand_species_i(s1_species_q),
    .ref_pt_i      (s1_rpt_q),
    .ref_eta_i     (s1_reta_q),
    .ref_phi_i     (s1_rphi_q),
    .cand_o        (s2_cand_d)
  );

  cmms_acc u_acc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (s2_fire),
    .last_i        (s2_last_q),
    .cand_i        (s2_cand_q),
    .out_stall_i   (out_stall_i),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .found_o       (found_o),
    .best_species_o(best_species_o),
    .best_pt_out_o (best_pt_out_o)
  );

`ifndef SYNTHESIS
  // An empty input register never pushes back.
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  // A pass that closes in the accumulator always produces a result beat.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && s2_last_q) |=> out_valid_o)
    else $error("closed pass produced no result beat");

  // A result without a match carries the empty values.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (best_species_o == NoSpecies && best_pt_out_o == '0))
    else $error("empty result carries stale match fields");
`endif

endmodule
